// File: design/windowed_page_bank_translator_macros.svh
// Assertion macros for the windowed page bank translator.
`ifndef WINDOWED_PAGE_BANK_TRANSLATOR_MACROS_SVH
`define WINDOWED_PAGE_BANK_TRANSLATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define WPBT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("wpbt assertion failed");
`define WPBT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("wpbt assertion failed");
`else
`define WPBT_ASSERT(label, clk, rstn, prop)
`define WPBT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: design/wpbt_pkg.sv
`timescale 1ns / 1ps

package wpbt_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FETCH = 2'd2,
        OP_DATA  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TGT_RAM  = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_IO   = 2'd2,
        TGT_NONE = 2'd3
    } target_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  reg_index;
        logic [15:0] write_data;
        logic [1:0]  byte_enable;
        logic [15:0] cpu_address;
    } in_t;

    typedef struct packed {
        logic [15:0] read_data;
        target_t     target;
        logic [25:0] phys_address;
    } out_t;

    localparam logic [15:0] ROM_PAGE_RESET = 16'h0780;
    localparam logic [15:0] DATA1_RESET    = 16'h0010;
    localparam logic [15:0] DATA2_RESET    = 16'h0020;
    localparam logic [1:0]  IO_WINDOW      = 2'd3;
    localparam logic [1:0]  ROM_WINDOW     = 2'd0;

    function automatic logic [15:0] page_reset(input logic [2:0] idx);
        logic [15:0] val;
        case (idx)
            3'd0: val = ROM_PAGE_RESET;
            3'd5: val = DATA1_RESET;
            3'd6: val = DATA2_RESET;
            default: val = 16'h0000;
        endcase
        return val;
    endfunction

endpackage

// File: design/windowed_page_bank_translator.sv
`timescale 1ns / 1ps
`include "windowed_page_bank_translator_macros.svh"

// Page bank translator for a 16-bit CPU. Eight page registers (four for
// instruction fetch, four for data, one per 16KB window) sit in a small
// synchronous RAM; each has a valid bit so that unwritten entries read as
// their reset value, and no clearing pass is needed after reset. Every
// transfer goes through two steps, the RAM read and then the decode, merge
// and write back; no new item is accepted until the result is registered.
// The result sits in an output register, so the next item may enter while
// it waits. The boot ROM page is set through the configuration write port.
module windowed_page_bank_translator #(
    parameter int RAM_BYTES    = 524288,
    parameter int PAGE_BITS    = 10,
    parameter int WINDOW_BYTES = 16384
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  wpbt_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output wpbt_pkg::out_t  m_data,
    input  logic            cfg_wr_en,
    input  logic [15:0]     cfg_wr_data
);
    import wpbt_pkg::*;

    localparam int OFF_W = $clog2(WINDOW_BYTES);
    localparam logic [31:0] RAM_LIMIT = 32'(RAM_BYTES);

    logic [15:0] mem [8];

    logic        busy_reg, busy_next;
    logic [7:0]  valid_reg, valid_next;
    logic [15:0] rom_page_reg, rom_page_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    in_t         req_reg;
    logic [2:0]  idx_reg;
    logic [15:0] rdata_reg;
    logic        rvalid_reg;

    logic        accept;
    logic        done;
    logic        mem_we;
    logic [2:0]  rd_idx;
    logic [15:0] page;
    logic [15:0] mask;
    logic [15:0] wr_value;
    logic [1:0]  win;
    logic [25:0] offset;
    logic [31:0] base;
    logic [31:0] sum;
    logic        io_hit, ram_hit, rom_hit;
    out_t        result;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign done    = busy_reg && (!m_valid_reg || m_ready);
    assign mem_we  = done && (req_reg.op == OP_WRITE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (s_data.op == OP_FETCH || s_data.op == OP_DATA) begin
            rd_idx = {s_data.op == OP_DATA, s_data.cpu_address[15:14]};
        end else begin
            rd_idx = s_data.reg_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg] <= wr_value;
        end
        if (accept) begin
            rdata_reg  <= mem[rd_idx];
            rvalid_reg <= valid_reg[rd_idx];
            req_reg    <= s_data;
            idx_reg    <= rd_idx;
        end
    end

    always_comb begin
        page     = rvalid_reg ? rdata_reg : page_reset(idx_reg);
        mask     = {{8{req_reg.byte_enable[1]}}, {8{req_reg.byte_enable[0]}}};
        wr_value = (page & ~mask) | (req_reg.write_data & mask);
        win      = req_reg.cpu_address[15:14];
        offset   = 26'(req_reg.cpu_address[OFF_W-1:0]);
        base     = 32'(page) << PAGE_BITS;
        sum      = base + 32'(offset);
        io_hit   = (req_reg.op == OP_DATA) && (win == IO_WINDOW) && (page == 16'h0000);
        ram_hit  = base < RAM_LIMIT;
        rom_hit  = (win == ROM_WINDOW) && (page == rom_page_reg);

        result = '{read_data: 16'h0000, target: TGT_RAM, phys_address: 26'd0};
        case (req_reg.op)
            OP_READ: begin
                result.read_data = page;
            end
            OP_WRITE: begin
                result.read_data = 16'h0000;
            end
            default: begin
                if (io_hit) begin
                    result.target       = TGT_IO;
                    result.phys_address = offset;
                end else if (ram_hit) begin
                    result.target       = TGT_RAM;
                    result.phys_address = sum[25:0];
                end else if (rom_hit) begin
                    result.target       = TGT_ROM;
                    result.phys_address = offset;
                end else begin
                    result.target       = TGT_NONE;
                    result.phys_address = sum[25:0];
                end
            end
        endcase
    end

    always_comb begin
        busy_next     = busy_reg;
        valid_next    = valid_reg;
        rom_page_next = cfg_wr_en ? cfg_wr_data : rom_page_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (done) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            m_data_next  = result;
        end
        if (mem_we) begin
            valid_next[idx_reg] = 1'b1;
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            valid_reg    <= '0;
            rom_page_reg <= ROM_PAGE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            valid_reg    <= valid_next;
            rom_page_reg <= rom_page_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `WPBT_ASSERT(a_one_in_flight, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `WPBT_ASSERT(a_done_gives_result, aclk, aresetn, done |=> (m_valid && !busy_reg))
    `WPBT_ASSERT(a_write_marks_valid, aclk, aresetn, mem_we |=> (valid_reg[$past(idx_reg)]))
    `WPBT_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!m_valid && s_ready))

endmodule

// File: tb/tb_windowed_page_bank_translator.sv
`timescale 1ns / 1ps

module tb_windowed_page_bank_translator;
    import wpbt_pkg::*;

    localparam int RAM_BYTES       = 524288;
    localparam int PAGE_BITS       = 10;
    localparam int WINDOW_BYTES    = 16384;
    localparam int DIRECTED_ROWS   = 25;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 72;

    typedef struct {
        in_t  access;
        bit   known;
        out_t result;
    } access_row_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_t         s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_t        m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    logic [15:0] bank_pages [8] = '{ROM_PAGE_RESET, 16'h0000, 16'h0000, 16'h0000,
                                    16'h0000, DATA1_RESET, DATA2_RESET, 16'h0000};
    logic [15:0] rom_page_model = ROM_PAGE_RESET;
    out_t        pending_results [$];
    int          mismatches = 0;
    bit          idling_on = 1'b1;

    windowed_page_bank_translator #(
        .RAM_BYTES   (RAM_BYTES),
        .PAGE_BITS   (PAGE_BITS),
        .WINDOW_BYTES(WINDOW_BYTES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("windowed_page_bank_translator: mismatch");
        $finish;
    end

    function automatic out_t predict_bank_access(input in_t access);
        out_t        res;
        logic [1:0]  window;
        logic [15:0] offset;
        logic [15:0] page;
        logic [15:0] mask;
        logic [26:0] base;
        res    = '0;
        window = access.cpu_address[15:14];
        offset = access.cpu_address & 16'(WINDOW_BYTES - 1);
        case (access.op)
            OP_READ: begin
                res.read_data = bank_pages[access.reg_index];
            end
            OP_WRITE: begin
                mask = {{8{access.byte_enable[1]}}, {8{access.byte_enable[0]}}};
                bank_pages[access.reg_index] = (bank_pages[access.reg_index] & ~mask)
                                               | (access.write_data & mask);
            end
            default: begin
                page = bank_pages[{access.op == OP_DATA, window}];
                base = 27'(page) << PAGE_BITS;
                if (access.op == OP_DATA && window == IO_WINDOW && page == 16'h0000) begin
                    res.target       = TGT_IO;
                    res.phys_address = 26'(offset);
                end else if (base < 27'(RAM_BYTES)) begin
                    res.target       = TGT_RAM;
                    res.phys_address = 26'(base + 27'(offset));
                end else if (window == ROM_WINDOW && page == rom_page_model) begin
                    res.target       = TGT_ROM;
                    res.phys_address = 26'(offset);
                end else begin
                    res.target       = TGT_NONE;
                    res.phys_address = 26'(base + 27'(offset));
                end
            end
        endcase
        return res;
    endfunction

    function automatic access_row_t step_row(input op_t op, input logic [2:0] idx,
                                             input logic [15:0] wdata,
                                             input logic [1:0] be,
                                             input logic [15:0] addr);
        access_row_t row;
        row.access = '{op, idx, wdata, be, addr};
        row.known  = 1'b0;
        row.result = '0;
        return row;
    endfunction

    function automatic access_row_t known_row(input op_t op, input logic [2:0] idx,
                                              input logic [15:0] wdata,
                                              input logic [1:0] be,
                                              input logic [15:0] addr,
                                              input logic [15:0] rdata,
                                              input target_t tgt,
                                              input logic [25:0] phys);
        access_row_t row;
        row = step_row(op, idx, wdata, be, addr);
        row.known  = 1'b1;
        row.result = '{rdata, tgt, phys};
        return row;
    endfunction

    function automatic in_t random_access();
        in_t access;
        access.op          = op_t'($urandom_range(0, 3));
        access.reg_index   = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0: access.write_data = 16'($urandom_range(0, 511));
            1: access.write_data = rom_page_model;
            2: access.write_data = 16'h0000;
            3: access.write_data = 16'($urandom_range(512, 2047));
            default: access.write_data = 16'($urandom);
        endcase
        access.byte_enable = $urandom_range(0, 1) ? 2'b11 : 2'($urandom_range(0, 2));
        access.cpu_address = 16'($urandom);
        return access;
    endfunction

    task automatic send_access(input in_t access, input bit known, input out_t result);
        out_t predicted;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= access;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_bank_access(access);
        pending_results.push_back(known ? result : predicted);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_rom_page(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        rom_page_model  = value;
    endtask

    // The receiver stalls in bursts whenever idling is enabled for the phase.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (idling_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, got %h",
                         $time, m_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h, got %h",
                             $time, want.read_data, m_data.read_data);
                    mismatches++;
                end
                if (m_data.target !== want.target) begin
                    $display("%0t: target expected %0d, got %0d",
                             $time, want.target, m_data.target);
                    mismatches++;
                end
                if (m_data.phys_address !== want.phys_address) begin
                    $display("%0t: phys_address expected %h, got %h",
                             $time, want.phys_address, m_data.phys_address);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        access_row_t directed_rows [DIRECTED_ROWS];
        logic [15:0] rom_settings [PHASES];
        directed_rows = '{
            known_row(OP_READ,  3'd0, 16'h0000, 2'b00, 16'h0000, ROM_PAGE_RESET, TGT_RAM, 26'h0),
            known_row(OP_READ,  3'd5, 16'hFFFF, 2'b11, 16'hFFFF, DATA1_RESET, TGT_RAM, 26'h0),
            known_row(OP_READ,  3'd6, 16'h0000, 2'b00, 16'h0000, DATA2_RESET, TGT_RAM, 26'h0),
            known_row(OP_READ,  3'd7, 16'h0000, 2'b00, 16'h0000, 16'h0000, TGT_RAM, 26'h0),
            known_row(OP_FETCH, 3'd0, 16'h0000, 2'b00, 16'h0000, 16'h0000, TGT_ROM, 26'h0),
            known_row(OP_FETCH, 3'd7, 16'hFFFF, 2'b11, 16'h3FFF, 16'h0000, TGT_ROM, 26'h3FFF),
            known_row(OP_DATA,  3'd0, 16'h0000, 2'b00, 16'hC123, 16'h0000, TGT_IO, 26'h0123),
            known_row(OP_FETCH, 3'd0, 16'h0000, 2'b00, 16'hC123, 16'h0000, TGT_RAM, 26'h0123),
            step_row(OP_DATA,   3'd0, 16'h0000, 2'b00, 16'h4000),
            known_row(OP_WRITE, 3'd1, 16'hFFFF, 2'b00, 16'hFFFF, 16'h0000, TGT_RAM, 26'h0),
            known_row(OP_READ,  3'd1, 16'h0000, 2'b00, 16'h0000, 16'h0000, TGT_RAM, 26'h0),
            step_row(OP_WRITE,  3'd1, 16'hABCD, 2'b01, 16'h0000),
            step_row(OP_READ,   3'd1, 16'h0000, 2'b00, 16'h0000),
            step_row(OP_WRITE,  3'd1, 16'h1234, 2'b10, 16'h0000),
            step_row(OP_READ,   3'd1, 16'h0000, 2'b00, 16'h0000),
            step_row(OP_WRITE,  3'd2, 16'hFFFF, 2'b11, 16'h0000),
            known_row(OP_FETCH, 3'd0, 16'h0000, 2'b00, 16'hBFFF, 16'h0000, TGT_NONE, 26'h3BFF),
            step_row(OP_WRITE,  3'd0, 16'h01FF, 2'b11, 16'h0000),
            step_row(OP_FETCH,  3'd0, 16'h0000, 2'b00, 16'h0000),
            step_row(OP_WRITE,  3'd0, 16'h0200, 2'b11, 16'h0000),
            step_row(OP_FETCH,  3'd0, 16'h0000, 2'b00, 16'h2000),
            step_row(OP_WRITE,  3'd4, 16'h0780, 2'b11, 16'h0000),
            step_row(OP_DATA,   3'd0, 16'h0000, 2'b00, 16'h0010),
            step_row(OP_WRITE,  3'd7, 16'h0001, 2'b11, 16'h0000),
            step_row(OP_DATA,   3'd0, 16'h0000, 2'b00, 16'hFFFF)
        };
        rom_settings = '{16'hFFFF, 16'h0000, 16'($urandom_range(512, 65535)),
                         ROM_PAGE_RESET, 16'($urandom), 16'h0200};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_access(directed_rows[i].access, directed_rows[i].known,
                        directed_rows[i].result);
        end
        drain_results();

        // Each phase runs with its own boot ROM page; phase 2 and the last run at full rate.
        for (int phase = 0; phase < PHASES; phase++) begin
            idling_on = (phase != 2) && (phase != PHASES - 1);
            write_rom_page(rom_settings[phase]);
            repeat (ITEMS_PER_PHASE) send_access(random_access(), 1'b0, '0);
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("windowed_page_bank_translator: match");
        end else begin
            $display("windowed_page_bank_translator: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/wpbt_pkg.sv
design/windowed_page_bank_translator.sv
tb/tb_windowed_page_bank_translator.sv
